// ===== hw/rtl/printable_string_extractor_top_defines.svh =====
// ----------------------------------------------------------------------------
// Printable string extractor assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PRINTABLE_STRING_EXTRACTOR_TOP_DEFINES_SVH
`define PRINTABLE_STRING_EXTRACTOR_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PSE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define PSE_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== hw/rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// Printable string extractor package
// Sizes, register indexes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int MAX_STRING = 64;
  localparam int ADDR_W     = $clog2(MAX_STRING);
  localparam int LEN_W      = $clog2(MAX_STRING + 1);
  localparam int MIN_W      = 6;
  localparam int CFG_W      = 7;

  localparam logic       CFG_MIN_LEN = 1'b0;
  localparam logic       CFG_MAX_LEN = 1'b1;

  localparam logic [7:0] PRINT_LOW  = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted input word
    logic scan;       // evaluate the latched byte against the run state
    logic emit_load;  // load the character read from the run store
    logic emit_next;  // step to the next character of the kept run
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_start; // the scanned byte closed a run that is to be sent
    logic emit_last;  // the loaded character ends the run
  } status_t;

endpackage

// ===== hw/rtl/pse_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pse_datapath.sv =====
// ----------------------------------------------------------------------------
// Printable string extractor datapath
// Run state, run and previous-string stores, length checks and output word.
// ----------------------------------------------------------------------------
module pse_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  pse_pkg::cmd_t          cmd,
  output pse_pkg::status_t       status,
  input  logic [7:0]             in_byte,
  input  logic                   in_eos,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [pse_pkg::CFG_W-1:0] cfg_data,
  output logic [6:0]             out_char,
  output logic                   out_last
);

  logic [7:0]                    byte_q;
  logic                          eos_q;
  logic [pse_pkg::LEN_W-1:0]     run_length;
  logic                          run_active;
  logic                          gap_seen;
  logic                          matches_previous;
  logic [pse_pkg::LEN_W-1:0]     previous_length;
  logic [pse_pkg::LEN_W-1:0]     emit_len;
  logic [pse_pkg::ADDR_W-1:0]    emit_idx;
  logic [pse_pkg::MIN_W-1:0]     min_len;
  logic [pse_pkg::CFG_W-1:0]     max_len;

  logic [pse_pkg::LEN_W-1:0]     len0;
  logic                          room;
  logic                          printable;
  logic                          mismatch;
  logic                          match_next;
  logic [pse_pkg::LEN_W-1:0]     len_next;
  logic                          active_next;
  logic                          close_run;
  logic                          keep;
  logic                          dup;
  logic                          emit;
  logic [7:0]                    prev_rdata;
  logic [7:0]                    run_rdata;

  // A printable byte that starts a run is stored at position zero.
  assign len0      = run_active ? run_length : '0;
  assign room      = len0 < pse_pkg::LEN_W'(pse_pkg::MAX_STRING);
  assign printable = (byte_q >= pse_pkg::PRINT_LOW) && (byte_q <= pse_pkg::PRINT_HIGH);

  // The previous store is read at len0 while the controller idles, so the
  // entry is ready in the scan cycle. It is only used below previous_length.
  assign mismatch    = !room || (len0 >= previous_length) || (prev_rdata != byte_q);
  assign match_next  = printable ? ((run_active ? matches_previous : 1'b1) && !mismatch)
                                 : matches_previous;
  assign len_next    = (printable && room) ? len0 + pse_pkg::LEN_W'(1) : len0;
  assign active_next = printable || run_active;
  assign close_run   = (!printable && run_active && gap_seen) || (eos_q && active_next);

  assign keep = (len_next > {1'b0, min_len}) && (len_next > pse_pkg::LEN_W'(1)) &&
                (len_next < max_len) && (len_next < pse_pkg::LEN_W'(pse_pkg::MAX_STRING));
  assign dup  = match_next && (previous_length != '0) && (len_next == previous_length);
  assign emit = close_run && keep && !dup;

  assign status.emit_start = cmd.scan && emit;
  assign status.emit_last  = out_last;

  pse_ram #(.WIDTH(8), .DEPTH(pse_pkg::MAX_STRING)) u_run_ram (
    .clk   (clk),
    .we    (cmd.scan && printable && room),
    .waddr (len0[pse_pkg::ADDR_W-1:0]),
    .wdata (byte_q),
    .raddr (emit_idx),
    .rdata (run_rdata)
  );

  // Each character sent is copied into the previous-string store.
  pse_ram #(.WIDTH(8), .DEPTH(pse_pkg::MAX_STRING)) u_prev_ram (
    .clk   (clk),
    .we    (cmd.emit_load),
    .waddr (emit_idx),
    .wdata (run_rdata),
    .raddr (len0[pse_pkg::ADDR_W-1:0]),
    .rdata (prev_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length       <= '0;
      run_active       <= 1'b0;
      gap_seen         <= 1'b0;
      matches_previous <= 1'b0;
      previous_length  <= '0;
      min_len          <= pse_pkg::MIN_W'(3);
      max_len          <= pse_pkg::CFG_W'(pse_pkg::MAX_STRING);
      emit_idx         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pse_pkg::CFG_MIN_LEN: min_len <= cfg_data[pse_pkg::MIN_W-1:0];
          pse_pkg::CFG_MAX_LEN: max_len <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.scan) begin
        priority if (close_run) begin
          run_active       <= 1'b0;
          gap_seen         <= 1'b0;
          matches_previous <= 1'b0;
          run_length       <= '0;
        end else if (printable) begin
          run_active       <= 1'b1;
          gap_seen         <= 1'b0;
          matches_previous <= match_next;
          run_length       <= len_next;
        end else if (run_active) begin
          gap_seen <= 1'b1;
        end else begin
          // A non-printable byte outside a run leaves the run state alone.
        end
        if (eos_q) begin
          previous_length <= '0;
        end else if (emit) begin
          previous_length <= len_next;
        end
        if (emit) begin
          emit_idx <= '0;
        end
      end else if (cmd.emit_next) begin
        emit_idx <= emit_idx + pse_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_q <= in_byte;
      eos_q  <= in_eos;
    end
    if (cmd.scan && emit) begin
      emit_len <= len_next;
    end
    if (cmd.emit_load) begin
      out_char <= run_rdata[6:0];
      out_last <= ({1'b0, emit_idx} + pse_pkg::LEN_W'(1)) == emit_len;
    end
  end

endmodule

// ===== hw/rtl/pse_ctrl.sv =====
// ----------------------------------------------------------------------------
// Printable string extractor controller
// Sequences accept, scan and the character-by-character output of a run.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output pse_pkg::cmd_t    cmd,
  input  pse_pkg::status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_LOAD,
    S_HOLD
  } state_t;

  state_t state;

  assign cmd.capture   = s_tvalid && s_tready;
  assign cmd.scan      = (state == S_SCAN);
  assign cmd.emit_load = (state == S_LOAD);
  assign cmd.emit_next = (state == S_HOLD) && m_tready && !status.emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state    <= S_SCAN;
            s_tready <= 1'b0;
          end
        end
        S_SCAN: begin
          if (status.emit_start) begin
            state <= S_READ;
          end else begin
            state    <= S_IDLE;
            s_tready <= 1'b1;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          state    <= S_HOLD;
          m_tvalid <= 1'b1;
        end
        S_HOLD: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (status.emit_last) begin
              state    <= S_IDLE;
              s_tready <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state    <= S_IDLE;
          s_tready <= 1'b1;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/printable_string_extractor_top.sv =====
// ----------------------------------------------------------------------------
// Printable string extractor
// Finds runs of printable ASCII bytes in a byte stream and sends kept runs.
//
//   Channel | Direction | Word contents
//   s_*     | in        | tdata[7:0] data_byte, tlast end_of_stream
//   m_*     | out       | tdata[6:0] out_char, tdata[7] zero, tlast string_last
//   cfg_*   | in        | index 0 min_len, index 1 max_len, no read-back
//
// Each input word is accepted in the idle state and then scanned against
// the run state while the previous-string store answers the comparison.
// A kept run is then sent one character at a time, the controller stepping
// through its three states (store read, load, hand-off) for each character;
// the hand-off waits on m_tready, and no input word is taken until the run
// is sent. Reset is synchronous; both stores need no clearing after reset.
// ----------------------------------------------------------------------------
module printable_string_extractor_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] data_byte
  input  logic                      s_tlast,   // end_of_stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // [6:0] out_char, [7] zero
  output logic                      m_tlast,   // string_last
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [pse_pkg::CFG_W-1:0] cfg_data
);

  pse_pkg::cmd_t    cmd;
  pse_pkg::status_t status;
  logic [6:0]       out_char;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  pse_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (s_tdata),
    .in_eos    (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

// ===== hw/rtl/pse_checker.sv =====
// ----------------------------------------------------------------------------
// Printable string extractor port checker
// Watches the top-level ports and flags sequencing and payload slips.
// ----------------------------------------------------------------------------
`include "printable_string_extractor_top_defines.svh"

module pse_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A stalled output word holds its contents.
  `PSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

  // Input is never taken while a character waits on the output.
  `PSE_ASSERT_ALWAYS(a_one_side, !(s_tready && m_tvalid), "input ready while output word pending")

  // Every character sent is printable ASCII.
  `PSE_ASSERT_ALWAYS(a_printable, !m_tvalid || (m_tdata >= 8'h20 && m_tdata <= 8'h7E), "non-printable character sent")

  // An accepted word is scanned before the next one can enter.
  `PSE_ASSERT_NEXT(a_scan_gap, s_tvalid && s_tready, !s_tready && !m_tvalid, "input taken in the scan cycle")

endmodule

bind printable_string_extractor_top pse_checker u_pse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== verif/printable_string_extractor_top_tb.sv =====
// ----------------------------------------------------------------------------
// Printable string extractor testbench
// Streams bytes into the extractor and checks every emitted character against
// a behavioral prediction of the run, gap, length and duplicate rules. Covers
// directed corner cases, several min/max length settings, random idling on
// both streams and a long output hold that backs up the input.
// ----------------------------------------------------------------------------
module printable_string_extractor_top_tb;

  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [6:0] ch;
    logic       is_last;
  } char_word_t;

  typedef enum int {
    CLOSE_TWO_GAPS,
    CLOSE_ON_LAST,
    CLOSE_GAP_EOS,
    CLOSE_LONG_GAP
  } run_close_e;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;   // [7:0] data_byte
  logic             s_tlast = 1'b0; // end_of_stream
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // [6:0] out_char, [7] zero
  logic             m_tlast;        // string_last
  logic             cfg_we = 1'b0;
  logic             cfg_index = pse_pkg::CFG_MIN_LEN;
  logic [pse_pkg::CFG_W-1:0] cfg_data = '0;

  // Predicted state of the extractor.
  logic [7:0]  run_store  [pse_pkg::MAX_STRING];
  logic [7:0]  prev_store [pse_pkg::MAX_STRING];
  int unsigned run_len = 0;
  int unsigned prev_len = 0;
  bit          in_run = 1'b0;
  bit          gap_pending = 1'b0;
  bit          same_as_prev = 1'b0;
  logic [5:0]  min_len_cfg = 6'd3;
  logic [6:0]  max_len_cfg = 7'd64;

  char_word_t  pending_chars[$];
  logic [7:0]  last_run[$];

  int  errors = 0;
  int  words_sent = 0;
  int  chars_checked = 0;
  int  strings_checked = 0;
  int  hold_left = 0;
  bit  long_hold_req = 1'b0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;

  printable_string_extractor_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Timeout at %0t with %0d characters still expected", $time,
             pending_chars.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(pse_pkg::PRINT_LOW, pse_pkg::PRINT_HIGH));
  endfunction

  function automatic logic [7:0] rand_nonprint();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h00, pse_pkg::PRINT_LOW - 1));
    return 8'($urandom_range(pse_pkg::PRINT_HIGH + 1, 8'hFF));
  endfunction

  function automatic void close_run_predict();
    bit keep;
    bit dup;
    char_word_t word_q;
    keep = run_len > min_len_cfg && run_len > 1 && run_len < max_len_cfg &&
           run_len < pse_pkg::MAX_STRING;
    dup = same_as_prev && prev_len != 0 && run_len == prev_len;
    if (keep && !dup) begin
      for (int k = 0; k < run_len; k++) begin
        word_q.ch      = run_store[k][6:0];
        word_q.is_last = (k + 1 == run_len);
        pending_chars  = {pending_chars, word_q};
        prev_store[k]  = run_store[k];
      end
      prev_len = run_len;
    end
    in_run = 1'b0;
    gap_pending = 1'b0;
    same_as_prev = 1'b0;
    run_len = 0;
  endfunction

  function automatic void predict_byte(logic [7:0] data, logic eos);
    if (data >= pse_pkg::PRINT_LOW && data <= pse_pkg::PRINT_HIGH) begin
      if (!in_run) begin
        in_run = 1'b1;
        run_len = 0;
        same_as_prev = 1'b1;
      end
      gap_pending = 1'b0;
      // Bytes past the store are dropped, and the run can no longer match.
      if (run_len < pse_pkg::MAX_STRING) begin
        if (run_len >= prev_len || prev_store[run_len] != data) same_as_prev = 1'b0;
        run_store[run_len] = data;
        run_len++;
      end else begin
        same_as_prev = 1'b0;
      end
    end else if (in_run) begin
      if (gap_pending) close_run_predict();
      else gap_pending = 1'b1;
    end
    if (eos) begin
      if (in_run) close_run_predict();
      prev_len = 0;
    end
  endfunction

  // Output side: random stalls, an optional long hold, and the character check.
  always @(posedge clk) begin : receiver
    int gap;
    char_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected word, expected none, got char %h last %b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = pending_chars.pop_front();
          if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.is_last) begin
            $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                     $time, {1'b0, want.ch}, want.is_last, m_tdata, m_tlast);
            errors++;
          end
          chars_checked++;
          if (want.is_last) strings_checked++;
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        gap = receiver_idles ? idle_gap() : 0;
        if (gap == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          hold_left = gap - 1;
        end
      end
    end
  end

  task automatic send_word(logic [7:0] data, logic eos);
    int gap;
    gap = sender_idles ? idle_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    predict_byte(data, eos);
    words_sent++;
  endtask

  task automatic send_text(string text, bit eos_at_end);
    for (int i = 0; i < text.len(); i++)
      send_word(text[i], eos_at_end && i == text.len() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(logic [5:0] lo, logic [6:0] hi);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= pse_pkg::CFG_MIN_LEN;
    cfg_data  <= pse_pkg::CFG_W'(lo);
    @(posedge clk);
    cfg_index <= pse_pkg::CFG_MAX_LEN;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_len_cfg = lo;
    max_len_cfg = hi;
  endtask

  // One printable run, sometimes a repeat or near-repeat of the last one,
  // with an occasional single gap inside and one of several ways to close it.
  task automatic send_random_run();
    logic [7:0] run_q[$];
    int r;
    int len;
    run_close_e how;
    r = $urandom_range(0, 99);
    if (last_run.size() > 0 && r < 20) begin
      run_q = last_run;
    end else if (last_run.size() > 1 && r < 28) begin
      run_q = last_run;
      void'(run_q.pop_back());
    end else if (last_run.size() > 0 && last_run.size() < 72 && r < 36) begin
      run_q = {last_run, rand_printable()};
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 10);
      else if (r < 92) len = $urandom_range(11, 30);
      else len = $urandom_range(58, 70);
      repeat (len) run_q = {run_q, rand_printable()};
    end
    last_run = run_q;
    r = $urandom_range(0, 99);
    how = r < 60 ? CLOSE_TWO_GAPS : r < 75 ? CLOSE_ON_LAST : r < 90 ? CLOSE_GAP_EOS
        : CLOSE_LONG_GAP;
    foreach (run_q[i]) begin
      send_word(run_q[i], how == CLOSE_ON_LAST && i == run_q.size() - 1);
      if (i != run_q.size() - 1 && $urandom_range(0, 9) == 0) send_word(rand_nonprint(), 1'b0);
    end
    unique case (how)
      CLOSE_TWO_GAPS: begin
        send_word(rand_nonprint(), 1'b0);
        send_word(rand_nonprint(), 1'b0);
      end
      CLOSE_GAP_EOS: begin
        send_word(rand_nonprint(), 1'b1);
      end
      CLOSE_LONG_GAP: begin
        repeat ($urandom_range(3, 6)) send_word(rand_nonprint(), 1'b0);
      end
      default: ;
    endcase
  endtask

  task automatic run_random_phase(logic [5:0] lo, logic [6:0] hi, int count);
    int target;
    set_limits(lo, hi);
    sender_idles   = $urandom_range(0, 3) != 0;
    receiver_idles = $urandom_range(0, 3) != 0;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 6) == 0)
        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      else
        send_random_run();
    end
  endtask

  // Reset limits: gap skipping, both printable edges, duplicate drop,
  // a short run, and end of stream forgetting the previous string.
  task automatic test_directed_runs();
    send_word(8'h00, 1'b0);
    send_text(" ~AB", 1'b0);
    send_word(8'h1F, 1'b0);
    send_word("C", 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h00, 1'b0);
    send_text(" ~ABC", 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_text("xy", 1'b0);
    send_word(8'h01, 1'b1);
    send_text(" ~ABC", 1'b1);
  endtask

  task automatic test_limit_extremes();
    run_random_phase(6'd0, 7'd64, 80);
    run_random_phase(6'd0, 7'd2, 30);
    run_random_phase(6'd1, 7'd3, 50);
    run_random_phase(6'd63, 7'd64, 25);
  endtask

  // The output holds off while the input keeps coming, so the block backs up.
  task automatic test_output_backpressure();
    int target;
    set_limits(6'd0, 7'd64);
    sender_idles = 1'b0;
    long_hold_req = 1'b1;
    target = words_sent + 50;
    while (words_sent < target) send_random_run();
    sender_idles = 1'b1;
  endtask

  task automatic test_random_limits();
    repeat (4) run_random_phase(6'($urandom_range(0, 12)), 7'($urandom_range(2, 64)), 40);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_runs();
    test_limit_extremes();
    test_output_backpressure();
    test_random_limits();
    drain();
    $display("Sent %0d input words; checked %0d characters in %0d strings.",
             words_sent, chars_checked, strings_checked);
    $display("Limits ran from min 0 / max 2 to min 63 / max 64, with a long output hold.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pse_pkg.sv
hw/rtl/pse_ram.sv
hw/rtl/pse_datapath.sv
hw/rtl/pse_ctrl.sv
hw/rtl/printable_string_extractor_top.sv
hw/rtl/pse_checker.sv
verif/printable_string_extractor_top_tb.sv
